// ===== sv/dtti_pkg.sv =====
// ----------------------------------------------------------------------------
// dtti_pkg
// Shared types, codes and format limits of the decimal text parser.
// ----------------------------------------------------------------------------
package dtti_pkg;

   // Number formats held in the number_format register.
   localparam logic [1:0] FMT_S32 = 2'd0;
   localparam logic [1:0] FMT_U32 = 2'd1;
   localparam logic [1:0] FMT_S64 = 2'd2;
   localparam logic [1:0] FMT_U64 = 2'd3;

   // Register byte addresses on the configuration port.
   localparam int unsigned ADDR_BITS = 3;
   localparam logic [ADDR_BITS-1:0] REG_NUMBER_FORMAT = 3'd0;

   // Character codes.
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_DIGITS = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       start_field;
      logic       end_of_text;
   } item_type;

   // A finished number as the step stage hands it to the output stage.
   typedef struct packed {
      logic [63:0] magnitude;
      logic        negative;
      status_type  status;
      logic [15:0] count;
      logic        stopped;
   } number_type;

   function automatic logic fmt_signed(logic [1:0] fmt);
      return ~fmt[0];
   endfunction

   function automatic logic fmt_wide(logic [1:0] fmt);
      return fmt[1];
   endfunction

   // Largest magnitude of the format; neg is the sign in a signed format.
   function automatic logic [63:0] mag_limit(logic [1:0] fmt, logic neg);
      logic [63:0] lim;
      priority if (fmt_wide(fmt) && !fmt_signed(fmt)) lim = 64'hFFFF_FFFF_FFFF_FFFF;
      else if (fmt_wide(fmt) && neg)                  lim = 64'h8000_0000_0000_0000;
      else if (fmt_wide(fmt))                         lim = 64'h7FFF_FFFF_FFFF_FFFF;
      else if (!fmt_signed(fmt))                      lim = 64'h0000_0000_FFFF_FFFF;
      else if (neg)                                   lim = 64'h0000_0000_8000_0000;
      else                                            lim = 64'h0000_0000_7FFF_FFFF;
      return lim;
   endfunction

   // The limit divided by ten.
   function automatic logic [63:0] limit_quot(logic [1:0] fmt);
      logic [63:0] q;
      priority if (fmt_wide(fmt) && !fmt_signed(fmt)) q = 64'd1844674407370955161;
      else if (fmt_wide(fmt))                         q = 64'd922337203685477580;
      else if (!fmt_signed(fmt))                      q = 64'd429496729;
      else                                            q = 64'd214748364;
      return q;
   endfunction

   // The last decimal digit of the limit.
   function automatic logic [3:0] limit_rem(logic [1:0] fmt, logic neg);
      logic [3:0] r;
      priority if (!fmt_signed(fmt)) r = 4'd5;
      else if (neg)                  r = 4'd8;
      else                           r = 4'd7;
      return r;
   endfunction

endpackage

// ===== sv/dtti_step.sv =====
// ----------------------------------------------------------------------------
// dtti_step
// Per-byte parse step: holds the running number and registers each finished
// number for the output stage.
// ----------------------------------------------------------------------------
module dtti_step #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                number_take,
   input  dtti_pkg::item_type  item,
   input  logic [1:0]          number_format,
   output logic                number_valid,
   output dtti_pkg::number_type number_out
);

   localparam int unsigned WIDE_BITS = COUNT_BITS + 16;

   logic [63:0]           mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   dtti_pkg::status_type  status_ff, status_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  sign_allowed_ff, sign_allowed_in;
   logic                  active_ff, active_in;
   logic                  number_valid_ff, number_valid_in;
   dtti_pkg::number_type  number_ff, number_in;

   logic [63:0]           cur_mag;
   logic                  cur_neg;
   dtti_pkg::status_type  cur_status;
   logic [COUNT_BITS-1:0] cur_count;
   logic                  cur_sign_allowed;
   logic                  active;
   logic                  is_signed;
   logic                  is_plus, is_minus, is_sign, is_digit;
   logic [3:0]            digit;
   logic [63:0]           lim, quot;
   logic [3:0]            rem;
   logic                  over;
   logic [63:0]           mag_times_ten;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  produce, stopped;
   logic [COUNT_BITS-1:0] out_count;
   logic [WIDE_BITS-1:0]  out_count_wide;

   always_comb begin
      // A start byte opens the number from a fresh state.
      cur_mag          = item.start_field ? 64'd0 : mag_ff;
      cur_neg          = item.start_field ? 1'b0 : neg_ff;
      cur_status       = item.start_field ? dtti_pkg::STATUS_NO_DIGITS : status_ff;
      cur_count        = item.start_field ? '0 : count_ff;
      cur_sign_allowed = item.start_field | sign_allowed_ff;
      active           = item.start_field | active_ff;

      is_signed = dtti_pkg::fmt_signed(number_format);
      is_plus   = (item.char_code == dtti_pkg::CHAR_PLUS);
      is_minus  = (item.char_code == dtti_pkg::CHAR_MINUS);
      is_sign   = cur_sign_allowed && (is_plus || (is_minus && is_signed));
      is_digit  = (item.char_code >= dtti_pkg::CHAR_ZERO) &&
                  (item.char_code <= dtti_pkg::CHAR_NINE);
      digit     = item.char_code[3:0];

      lim  = dtti_pkg::mag_limit(number_format, cur_neg && is_signed);
      quot = dtti_pkg::limit_quot(number_format);
      rem  = dtti_pkg::limit_rem(number_format, cur_neg && is_signed);
      over = (cur_mag > quot) || ((cur_mag == quot) && (digit > rem));
      mag_times_ten = (cur_mag << 3) + (cur_mag << 1) + {60'd0, digit};
      count_inc = (cur_count != '1) ? cur_count + 1'b1 : cur_count;

      mag_in          = cur_mag;
      neg_in          = cur_neg;
      status_in       = cur_status;
      count_in        = cur_count;
      sign_allowed_in = cur_sign_allowed;
      active_in       = active;
      produce         = 1'b0;
      stopped         = 1'b0;

      if (active) begin
         priority if (is_sign) begin
            neg_in          = is_minus;
            sign_allowed_in = 1'b0;
            count_in        = count_inc;
         end else if (is_digit) begin
            sign_allowed_in = 1'b0;
            count_in        = count_inc;
            if (cur_status != dtti_pkg::STATUS_RANGE) begin
               mag_in    = over ? lim : mag_times_ten;
               status_in = over ? dtti_pkg::STATUS_RANGE : dtti_pkg::STATUS_OK;
            end
         end else begin
            // The byte is not part of the number and ends it unconsumed.
            produce   = 1'b1;
            stopped   = 1'b1;
            active_in = 1'b0;
         end
         if ((is_sign || is_digit) && item.end_of_text) begin
            produce   = 1'b1;
            active_in = 1'b0;
         end
      end

      // A stopped number reports the state before this byte.
      out_count      = stopped ? cur_count : count_in;
      out_count_wide = {16'd0, out_count};

      number_in.magnitude = stopped ? cur_mag : mag_in;
      number_in.negative  = stopped ? cur_neg : neg_in;
      number_in.status    = stopped ? cur_status : status_in;
      number_in.count     = (out_count_wide > WIDE_BITS'(16'hFFFF)) ?
                            16'hFFFF : out_count_wide[15:0];
      number_in.stopped   = stopped;

      if (step_en) begin
         number_valid_in = produce;
      end else if (number_take) begin
         number_valid_in = 1'b0;
      end else begin
         number_valid_in = number_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff          <= 64'd0;
         neg_ff          <= 1'b0;
         status_ff       <= dtti_pkg::STATUS_NO_DIGITS;
         count_ff        <= '0;
         sign_allowed_ff <= 1'b1;
         active_ff       <= 1'b0;
         number_valid_ff <= 1'b0;
      end else begin
         number_valid_ff <= number_valid_in;
         if (step_en) begin
            mag_ff          <= mag_in;
            neg_ff          <= neg_in;
            status_ff       <= status_in;
            count_ff        <= count_in;
            sign_allowed_ff <= sign_allowed_in;
            active_ff       <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && produce) begin
         number_ff <= number_in;
      end
   end

   assign number_valid = number_valid_ff;
   assign number_out   = number_ff;

endmodule

// ===== sv/dtti_emit.sv =====
// ----------------------------------------------------------------------------
// dtti_emit
// Output stage: clamps a finished magnitude to the format, applies the sign
// and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module dtti_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  dtti_pkg::number_type number_in,
   input  logic [1:0]           number_format,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [63:0]          rsp_value,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_bytes_consumed,
   output logic                 rsp_stopped_on_byte
);

   logic                 valid_ff, valid_in;
   logic [63:0]          value_ff, value_in;
   dtti_pkg::status_type status_ff, status_in;
   logic [15:0]          count_ff;
   logic                 stopped_ff;

   logic        neg_eff;
   logic [63:0] lim;
   logic        over;

   always_comb begin
      neg_eff = number_in.negative && dtti_pkg::fmt_signed(number_format);
      lim     = dtti_pkg::mag_limit(number_format, neg_eff);
      over    = number_in.magnitude > lim;

      // Both negations are formed in parallel with the compare.
      if (neg_eff) begin
         value_in = over ? (64'd0 - lim) : (64'd0 - number_in.magnitude);
      end else begin
         value_in = over ? lim : number_in.magnitude;
      end
      if (!dtti_pkg::fmt_wide(number_format)) begin
         value_in[63:32] = 32'd0;
      end

      status_in = over ? dtti_pkg::STATUS_RANGE : number_in.status;
      if (number_in.status == dtti_pkg::STATUS_NO_DIGITS) begin
         value_in  = 64'd0;
         status_in = dtti_pkg::STATUS_NO_DIGITS;
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff   <= value_in;
         status_ff  <= status_in;
         count_ff   <= number_in.count;
         stopped_ff <= number_in.stopped;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_value           = value_ff;
   assign rsp_status          = status_ff;
   assign rsp_bytes_consumed  = count_ff;
   assign rsp_stopped_on_byte = stopped_ff;

endmodule

// ===== sv/decimal_text_to_integer.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_integer
// Streaming saturating ASCII decimal parser in four integer formats.
//
//   channel   direction  handshake        payload
//   req       in         valid / ready    char_code, start_field, end_of_text
//   rsp       out        valid / ready    value, status, bytes_consumed,
//                                         stopped_on_byte
//   csr       in         APB, pready=1    number_format at byte address 0
//
// One byte is accepted per cycle when the result side keeps up.
// The byte ending a number passes the input, parse step and output registers
// in turn before its result is valid.
// The parse step's multiply by ten and limit compare set the cycle time.
// Reset clears all control state and sets number_format to signed 32-bit.
// A stalled result holds the output register; the stage behind it keeps
// taking bytes until its own pending number has nowhere to go.
// ----------------------------------------------------------------------------
module decimal_text_to_integer #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_start_field,
   input  logic        req_end_of_text,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_bytes_consumed,
   output logic        rsp_stopped_on_byte,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [dtti_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [1:0]           format_ff, format_in;
   logic                 in_valid_ff, in_valid_in;
   dtti_pkg::item_type   in_item_ff;

   logic                 step_en;
   logic                 number_valid;
   logic                 number_take;
   logic                 out_free;
   dtti_pkg::number_type number;
   logic                 csr_write;
   logic                 csr_hit;

   // Configuration register.
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[dtti_pkg::ADDR_BITS-1:2] ==
                       dtti_pkg::REG_NUMBER_FORMAT[dtti_pkg::ADDR_BITS-1:2]);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign format_in = csr_write ? pwdata[1:0] : format_ff;
   assign prdata    = csr_hit ? {30'd0, format_ff} : 32'd0;

   // Backpressure chain from the result side to the input register.
   assign out_free    = !rsp_valid || rsp_ready;
   assign number_take = number_valid && out_free;
   assign step_en     = in_valid_ff && (!number_valid || number_take);
   assign req_ready   = !in_valid_ff || step_en;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff   <= dtti_pkg::FMT_S32;
         in_valid_ff <= 1'b0;
      end else begin
         format_ff   <= format_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.char_code   <= req_char_code;
         in_item_ff.start_field <= req_start_field;
         in_item_ff.end_of_text <= req_end_of_text;
      end
   end

   dtti_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .number_take   (number_take),
      .item          (in_item_ff),
      .number_format (format_ff),
      .number_valid  (number_valid),
      .number_out    (number)
   );

   dtti_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .load                (number_take),
      .number_in           (number),
      .number_format       (format_ff),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_value           (rsp_value),
      .rsp_status          (rsp_status),
      .rsp_bytes_consumed  (rsp_bytes_consumed),
      .rsp_stopped_on_byte (rsp_stopped_on_byte)
   );

   // The input register only refuses a byte while it holds one.
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> in_valid_ff)
      else $error("input stalled while its register is empty");

   // A number with no digits always reports a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dtti_pkg::STATUS_NO_DIGITS) |-> (rsp_value == 64'd0))
      else $error("no-digit result carries a nonzero value");

   // Only the three defined status codes leave the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == dtti_pkg::STATUS_OK) ||
                    (rsp_status == dtti_pkg::STATUS_NO_DIGITS) ||
                    (rsp_status == dtti_pkg::STATUS_RANGE))
      else $error("undefined status code on result");

   // A pending number that cannot be handed on while the output stalls is not lost.
   assert property (@(posedge clock) disable iff (reset)
      number_valid && !out_free |=> number_valid)
      else $error("pending number dropped under backpressure");

endmodule

// ===== dv/tb_decimal_text_to_integer.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_text_to_integer
// Self-checking testbench for the streaming decimal text parser.
//
// Text bytes are offered on the request channel. Every accepted byte is run
// through a behavioral parser kept in this file, and each number it closes is
// queued. The checker compares each result word taken from the response
// channel, field by field, with the oldest queued number. Directed cases come
// first, then random text in all four number formats, under several mixes of
// sender gaps and receiver stalls, including one long receiver hold.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_integer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DECIMAL_BASE = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic [63:0]          value;
      dtti_pkg::status_type status;
      logic [15:0]          count;
      logic                 stopped;
   } parsed_number_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code   = '0;
   logic        req_start_field = 1'b0;
   logic        req_end_of_text = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_value;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_bytes_consumed;
   logic        rsp_stopped_on_byte;

   logic                           psel    = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite  = 1'b0;
   logic [dtti_pkg::ADDR_BITS-1:0] paddr   = '0;
   logic [31:0]                    pwdata  = '0;
   logic [31:0]                    prdata;
   logic                           pready;

   // Parser state as the block should hold it.
   logic [1:0]           fmt        = dtti_pkg::FMT_S32;
   logic [63:0]          acc_mag    = '0;
   logic                 acc_neg    = 1'b0;
   dtti_pkg::status_type acc_status = dtti_pkg::STATUS_NO_DIGITS;
   logic [15:0]          acc_count  = '0;
   logic                 sign_ok    = 1'b1;
   logic                 in_number  = 1'b0;

   parsed_number_type pending_numbers[$];

   int failures      = 0;
   int bytes_parsed  = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int stall_cycles  = 0;
   bit offering      = 1'b0;

   decimal_text_to_integer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_char_code       (req_char_code),
      .req_start_field     (req_start_field),
      .req_end_of_text     (req_end_of_text),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_value           (rsp_value),
      .rsp_status          (rsp_status),
      .rsp_bytes_consumed  (rsp_bytes_consumed),
      .rsp_stopped_on_byte (rsp_stopped_on_byte),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Behavioral parser
   // ---------------------------------------------------------------------
   function automatic logic is_signed_format(input logic [1:0] f);
      return (f == dtti_pkg::FMT_S32) || (f == dtti_pkg::FMT_S64);
   endfunction

   function automatic logic [63:0] format_limit(input logic [1:0] f, input logic neg);
      logic [63:0] lim;
      case (f)
         dtti_pkg::FMT_U64: lim = 64'hFFFF_FFFF_FFFF_FFFF;
         dtti_pkg::FMT_S64: lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         dtti_pkg::FMT_U32: lim = 64'h0000_0000_FFFF_FFFF;
         default:           lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      endcase
      return lim;
   endfunction

   function automatic parsed_number_type close_number(input logic stopped);
      parsed_number_type num;
      logic              neg;
      logic [63:0]       lim;
      logic [63:0]       mag;
      neg        = acc_neg && is_signed_format(fmt);
      lim        = format_limit(fmt, neg);
      mag        = acc_mag;
      num.status = acc_status;
      num.value  = '0;
      if (acc_status != dtti_pkg::STATUS_NO_DIGITS) begin
         // A format switch can leave more magnitude than the format holds.
         if (mag > lim) begin
            mag        = lim;
            num.status = dtti_pkg::STATUS_RANGE;
         end
         num.value = neg ? (64'd0 - mag) : mag;
         if (fmt == dtti_pkg::FMT_S32 || fmt == dtti_pkg::FMT_U32) num.value[63:32] = '0;
      end
      num.count   = acc_count;
      num.stopped = stopped;
      in_number   = 1'b0;
      return num;
   endfunction

   // Advances the parser by one byte; returns 1 when a number is closed.
   function automatic bit parse_byte(input logic [7:0] ch, input logic first,
                                     input logic last, output parsed_number_type num);
      logic [63:0] digit;
      logic [63:0] lim;
      logic        sgn;
      num = '0;
      if (first) begin
         acc_mag    = '0;
         acc_neg    = 1'b0;
         acc_status = dtti_pkg::STATUS_NO_DIGITS;
         acc_count  = '0;
         sign_ok    = 1'b1;
         in_number  = 1'b1;
      end
      if (!in_number) return 1'b0;
      sgn = is_signed_format(fmt);
      if (sign_ok && (ch == dtti_pkg::CHAR_PLUS || (ch == dtti_pkg::CHAR_MINUS && sgn))) begin
         acc_neg = (ch == dtti_pkg::CHAR_MINUS);
         sign_ok = 1'b0;
         if (acc_count != '1) acc_count++;
      end else if (ch >= dtti_pkg::CHAR_ZERO && ch <= dtti_pkg::CHAR_NINE) begin
         digit   = 64'(ch - dtti_pkg::CHAR_ZERO);
         lim     = format_limit(fmt, acc_neg && sgn);
         sign_ok = 1'b0;
         if (acc_count != '1) acc_count++;
         if (acc_status != dtti_pkg::STATUS_RANGE) begin
            if (acc_mag > lim / DECIMAL_BASE ||
                (acc_mag == lim / DECIMAL_BASE && digit > lim % DECIMAL_BASE)) begin
               acc_mag    = lim;
               acc_status = dtti_pkg::STATUS_RANGE;
            end else begin
               acc_mag    = acc_mag * DECIMAL_BASE + digit;
               acc_status = dtti_pkg::STATUS_OK;
            end
         end
      end else begin
         num = close_number(1'b1);
         return 1'b1;
      end
      if (last) begin
         num = close_number(1'b0);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   task automatic withdraw_req();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic send_byte(input logic [7:0] ch, input logic first, input logic last);
      parsed_number_type num;
      while ($urandom_range(99) < send_idle_pct) begin
         withdraw_req();
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_code   <= ch;
      req_start_field <= first;
      req_end_of_text <= last;
      offering = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (first || in_number) bytes_parsed++;
      if (parse_byte(ch, first, last, num)) pending_numbers.push_back(num);
   endtask

   task automatic send_text(input string text, input logic last_marks_end);
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i], i == 0, last_marks_end && (i == text.len() - 1));
   endtask

   task automatic drain_results();
      withdraw_req();
      while (pending_numbers.size() != 0) @(posedge clock);
      // Bytes that close nothing may still be in flight.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_format(input logic [1:0] f);
      logic [31:0] wdata;
      drain_results();
      wdata      = $urandom;
      wdata[1:0] = f;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= dtti_pkg::REG_NUMBER_FORMAT;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      fmt = f;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[1:0] !== f) begin
         failures++;
         if (failures <= 10)
            $display("number_format readback: expected %0d got %0d", f, prdata[1:0]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Random text
   // ---------------------------------------------------------------------
   function automatic string random_digits(input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
      return s;
   endfunction

   // Digit strings at and around the bounds of all formats.
   function automatic string near_limit_digits();
      string       s;
      logic [63:0] wide_value;
      case ($urandom_range(6))
         0:       s = "2147483647";
         1:       s = "2147483648";
         2:       s = "4294967295";
         3:       s = "9223372036854775807";
         4:       s = "9223372036854775808";
         5:       s = "18446744073709551615";
         default: begin
            wide_value = {$urandom, $urandom};
            s = $sformatf("%0d", wide_value);
         end
      endcase
      case ($urandom_range(5))
         0, 1: s = {s.substr(0, s.len() - 2), $sformatf("%0d", $urandom_range(9))};
         2:    s = {s, $sformatf("%0d", $urandom_range(9))};
         3:    s = s.substr(0, s.len() - 2);
         4:    s = {"00", s};
         default: ;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] stop_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c >= dtti_pkg::CHAR_ZERO && c <= dtti_pkg::CHAR_NINE);
      return c;
   endfunction

   task automatic send_random_sequence();
      string text;
      int    pick;
      pick = $urandom_range(99);
      if (pick < 12) begin
         send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
         return;
      end
      text = "";
      pick = $urandom_range(99);
      if (pick < 15)      text = "+";
      else if (pick < 30) text = "-";
      else if (pick < 34) text = $urandom_range(1) ? "+-" : "--";
      pick = $urandom_range(99);
      if (pick < 6)       text = text;
      else if (pick < 40) text = {text, near_limit_digits()};
      else if (pick < 48) text = {text, random_digits($urandom_range(1, 22))};
      else                text = {text, random_digits($urandom_range(1, 5))};
      pick = $urandom_range(99);
      if (pick < 40 && text.len() != 0) begin
         send_text(text, 1'b1);
      end else if (pick < 88 || text.len() == 0) begin
         send_text(text, 1'b0);
         send_byte(stop_char(), text.len() == 0, 1'($urandom_range(1)));
      end else begin
         // Left open; the next start drops it.
         send_text(text, 1'b0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Runs under the reset format, signed 32-bit.
   task automatic test_signs_and_markers();
      send_text("-0", 1'b1);
      send_text("+-", 1'b0);
      send_byte("x", 1'b0, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_text("12", 1'b0);
      send_text("7", 1'b1);
      send_text("5", 1'b0);
      send_byte(",", 1'b0, 1'b1);
      send_byte(8'h00, 1'b1, 1'b0);
   endtask

   task automatic test_unsigned_minus();
      write_format(dtti_pkg::FMT_U32);
      send_text("-9", 1'b0);
      send_text("+9", 1'b1);
   endtask

   task automatic test_format_switch();
      write_format(dtti_pkg::FMT_S32);
      send_text("-5", 1'b0);
      write_format(dtti_pkg::FMT_U32);
      send_text("3", 1'b1);
      send_text("3000000000", 1'b0);
      write_format(dtti_pkg::FMT_S32);
      send_byte(" ", 1'b0, 1'b1);
   endtask

   task automatic test_random_traffic(input int sender_gap, input int receiver_gap,
                                      input int budget);
      logic [1:0] formats [4];
      int         first;
      int         mark;
      formats       = '{dtti_pkg::FMT_S32, dtti_pkg::FMT_U32,
                        dtti_pkg::FMT_S64, dtti_pkg::FMT_U64};
      first         = $urandom_range(3);
      send_idle_pct = sender_gap;
      recv_idle_pct <= receiver_gap;
      for (int i = 0; i < 4; i++) begin
         write_format(formats[(first + i) % 4]);
         mark = bytes_parsed;
         while (bytes_parsed - mark < budget / 4) send_random_sequence();
      end
   endtask

   // The receiver holds off while short numbers keep coming, so the block
   // fills and stops taking bytes; then the sender waits for every result.
   task automatic test_output_stall();
      write_format(dtti_pkg::FMT_S64);
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 40; i++) send_text(random_digits($urandom_range(1, 3)), 1'b1);
      drain_results();
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_signs_and_markers();
      test_unsigned_minus();
      test_format_switch();
      test_random_traffic(26, 54, 520);
      test_output_stall();
      test_random_traffic(54, 26, 520);
      test_random_traffic(0, 0, 260);
      drain_results();
      if (failures == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------
   initial begin : result_receiver
      int seen_holds;
      seen_holds = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != seen_holds) begin
            seen_holds = hold_requests;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : result_checker
      parsed_number_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_numbers.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: value %h status %0d count %0d stopped %0b",
                        rsp_value, rsp_status, rsp_bytes_consumed, rsp_stopped_on_byte);
         end else begin
            want = pending_numbers.pop_front();
            if (rsp_value !== want.value || rsp_status !== want.status ||
                rsp_bytes_consumed !== want.count || rsp_stopped_on_byte !== want.stopped) begin
               failures++;
               if (failures <= 10) begin
                  $display("mismatch: expected value %h status %0d count %0d stopped %0b",
                           want.value, want.status, want.count, want.stopped);
                  $display("          actual   value %h status %0d count %0d stopped %0b",
                           rsp_value, rsp_status, rsp_bytes_consumed, rsp_stopped_on_byte);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog on cycles in which no word moves anywhere
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
